// ===== design/frt_pkg.sv =====
// ============================================================================
// frt_pkg - fragment reassembly tracker shared definitions
// Field widths, default parameter values, phase and event codes, beat types.
// ============================================================================
package frt_pkg;

    // default parameter values
    localparam int unsigned DEF_MAX_MESSAGE_LEN = 512;
    localparam int unsigned DEF_SLOTS           = 4;

    // channels per slot, fixed
    localparam int unsigned CHANNELS = 4;
    localparam int unsigned CHAN_W   = 2;

    // beat field widths
    localparam int unsigned SLOT_W   = 3;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OFFSET_W = 9;
    localparam int unsigned EVENT_W  = 3;
    localparam int unsigned MLEN_W   = 10;
    localparam int unsigned HLEN_W   = 16;
    localparam int unsigned SEQ_W    = 8;

    // packet phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_EXT13    = 3'd1;
    localparam logic [2:0] PH_EXT16_HI = 3'd2;
    localparam logic [2:0] PH_EXT16_LO = 3'd3;
    localparam logic [2:0] PH_BODY     = 3'd4;
    localparam logic [2:0] PH_DROP     = 3'd5;

    // header type field of a start byte
    localparam logic [1:0] HDR_GENERAL = 2'd0;
    localparam logic [1:0] HDR_EXT13   = 2'd1;
    localparam logic [1:0] HDR_EXT16   = 2'd2;

    // event codes
    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_DONE     = 3'd1;
    localparam logic [EVENT_W-1:0] EV_RESERVED = 3'd2;
    localparam logic [EVENT_W-1:0] EV_LARGE    = 3'd3;
    localparam logic [EVENT_W-1:0] EV_CUT      = 3'd4;
    localparam logic [EVENT_W-1:0] EV_ORPHAN   = 3'd5;
    localparam logic [EVENT_W-1:0] EV_SEQ      = 3'd6;
    localparam logic [EVENT_W-1:0] EV_IGNORED  = 3'd7;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic [CHAN_W-1:0] channel;
        logic [BYTE_W-1:0] packet_byte;
        logic              packet_start;
        logic              packet_end;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   out_slot;
        logic [CHAN_W-1:0]   out_channel;
        logic                payload_valid;
        logic [BYTE_W-1:0]   payload_byte;
        logic [OFFSET_W-1:0] payload_offset;
        logic [EVENT_W-1:0]  event_res;
        logic [MLEN_W-1:0]   message_length;
    } result_t;

    // per-stream status flags
    typedef struct packed {
        logic             active;
        logic [SEQ_W-1:0] seq;
    } stream_flags_t;

endpackage

// ===== design/frt_ifs.sv =====
// ============================================================================
// frt_ifs - beat channels of the fragment reassembly tracker
// Input packet-byte channel and output result channel, valid/ready.
// ============================================================================
interface frt_pkt_if;
    logic                        valid;
    logic                        ready;
    logic [frt_pkg::SLOT_W-1:0]  slot_index;
    logic [frt_pkg::CHAN_W-1:0]  channel;
    logic [frt_pkg::BYTE_W-1:0]  packet_byte;
    logic                        packet_start;
    logic                        packet_end;

    modport source (output valid, slot_index, channel, packet_byte, packet_start,
                    packet_end, input ready);
    modport sink   (input valid, slot_index, channel, packet_byte, packet_start,
                    packet_end, output ready);
endinterface

interface frt_res_if;
    logic                          valid;
    logic                          ready;
    logic [frt_pkg::SLOT_W-1:0]    out_slot;
    logic [frt_pkg::CHAN_W-1:0]    out_channel;
    logic                          payload_valid;
    logic [frt_pkg::BYTE_W-1:0]    payload_byte;
    logic [frt_pkg::OFFSET_W-1:0]  payload_offset;
    logic [frt_pkg::EVENT_W-1:0]   event_res;
    logic [frt_pkg::MLEN_W-1:0]    message_length;

    modport source (output valid, out_slot, out_channel, payload_valid, payload_byte,
                    payload_offset, event_res, message_length, input ready);
    modport sink   (input valid, out_slot, out_channel, payload_valid, payload_byte,
                    payload_offset, event_res, message_length, output ready);
endinterface

// ===== design/fragment_reassembly_tracker.sv =====
// ============================================================================
// fragment_reassembly_tracker - length-prefixed fragment reassembly
// Reassembles notification packets per slot/channel stream, one byte a beat.
// ============================================================================
// The block takes one packet byte per beat on pkt and gives exactly one
// result beat on res for every input beat, in order. Throughput is one beat
// per clock while res is not stalled: the byte sits in an input register,
// one pass of decode logic reads the per-stream state (flip-flops, one
// stream per slot/channel pair), and the result is written into the output
// register in the same cycle that the stream state and packet phase are
// updated, so the next byte already sees them. A result beat passes the
// input register and then the output register. A stalled res holds the
// result register; the input register still takes one more beat, after
// which pkt.ready drops until res drains. Stream state and packet phase
// reset at once with rst_n; no clearing pass is needed.
// ============================================================================
module fragment_reassembly_tracker #(
    parameter int unsigned MAX_MESSAGE_LEN = frt_pkg::DEF_MAX_MESSAGE_LEN,
    parameter int unsigned SLOTS           = frt_pkg::DEF_SLOTS
) (
    input logic       clk,
    input logic       rst_n,
    frt_pkt_if.sink   pkt,
    frt_res_if.source res
);
    import frt_pkg::*;

    localparam int unsigned STREAMS = SLOTS * CHANNELS;
    localparam int unsigned IDX_W   = $clog2(STREAMS);
    localparam int unsigned LEN_W   = $clog2(MAX_MESSAGE_LEN + 1);

    // input register
    logic    item_valid_reg, item_valid_next;
    item_t   item_reg;

    // result register
    logic    res_valid_reg, res_valid_next;
    result_t res_reg;
    result_t result;

    logic    out_free;
    logic    fire;
    logic    pkt_take;

    // stream table port
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] rd_len, rd_count, wr_len, wr_count;
    stream_flags_t    rd_flags, wr_flags;
    logic             wr_en;

    // a result slot is free when empty or being drained this cycle
    assign out_free  = !res_valid_reg || res.ready;
    assign fire      = item_valid_reg && out_free;
    assign pkt.ready = !item_valid_reg || fire;
    assign pkt_take  = pkt.valid && pkt.ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (pkt_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (fire)
        begin
            item_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pkt_take)
        begin
            item_reg.slot_index   <= pkt.slot_index;
            item_reg.channel      <= pkt.channel;
            item_reg.packet_byte  <= pkt.packet_byte;
            item_reg.packet_start <= pkt.packet_start;
            item_reg.packet_end   <= pkt.packet_end;
        end
        if (fire)
        begin
            res_reg <= result;
        end
    end

    frt_decoder #(
        .MAX_MESSAGE_LEN (MAX_MESSAGE_LEN),
        .SLOTS           (SLOTS),
        .LEN_W           (LEN_W),
        .IDX_W           (IDX_W)
    ) u_decoder (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (item_reg),
        .result   (result),
        .idx      (idx),
        .rd_len   (rd_len),
        .rd_count (rd_count),
        .rd_flags (rd_flags),
        .wr_en    (wr_en),
        .wr_len   (wr_len),
        .wr_count (wr_count),
        .wr_flags (wr_flags)
    );

    frt_stream_table #(
        .STREAMS (STREAMS),
        .LEN_W   (LEN_W),
        .IDX_W   (IDX_W)
    ) u_stream_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .idx      (idx),
        .rd_len   (rd_len),
        .rd_count (rd_count),
        .rd_flags (rd_flags),
        .wr_en    (wr_en),
        .wr_len   (wr_len),
        .wr_count (wr_count),
        .wr_flags (wr_flags)
    );

    // result channel
    assign res.valid          = res_valid_reg;
    assign res.out_slot       = res_reg.out_slot;
    assign res.out_channel    = res_reg.out_channel;
    assign res.payload_valid  = res_reg.payload_valid;
    assign res.payload_byte   = res_reg.payload_byte;
    assign res.payload_offset = res_reg.payload_offset;
    assign res.event_res      = res_reg.event_res;
    assign res.message_length = res_reg.message_length;

endmodule

// ===== design/frt_stream_table.sv =====
// ============================================================================
// frt_stream_table - per-stream reassembly state
// Expected length, received count, active flag and sequence per stream.
// ============================================================================
module frt_stream_table #(
    parameter int unsigned STREAMS = 16,
    parameter int unsigned LEN_W   = 10,
    parameter int unsigned IDX_W   = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IDX_W-1:0]       idx,
    output logic [LEN_W-1:0]       rd_len,
    output logic [LEN_W-1:0]       rd_count,
    output frt_pkg::stream_flags_t rd_flags,
    input  logic                   wr_en,
    input  logic [LEN_W-1:0]       wr_len,
    input  logic [LEN_W-1:0]       wr_count,
    input  frt_pkg::stream_flags_t wr_flags
);
    import frt_pkg::*;

    logic [LEN_W-1:0] len_reg   [STREAMS];
    logic [LEN_W-1:0] count_reg [STREAMS];
    stream_flags_t    flags_reg [STREAMS];

    assign rd_len   = len_reg[idx];
    assign rd_count = count_reg[idx];
    assign rd_flags = flags_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STREAMS; i++)
            begin
                len_reg[i]   <= '0;
                count_reg[i] <= '0;
                flags_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            len_reg[idx]   <= wr_len;
            count_reg[idx] <= wr_count;
            flags_reg[idx] <= wr_flags;
        end
    end

endmodule

// ===== design/frt_decoder.sv =====
// ============================================================================
// frt_decoder - packet header and body decode
// Tracks packet phase, parses headers, checks sequence, builds the result.
// ============================================================================
module frt_decoder #(
    parameter int unsigned MAX_MESSAGE_LEN = 512,
    parameter int unsigned SLOTS           = 4,
    parameter int unsigned LEN_W           = 10,
    parameter int unsigned IDX_W           = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  frt_pkg::item_t         item,
    output frt_pkg::result_t       result,
    output logic [IDX_W-1:0]       idx,
    input  logic [LEN_W-1:0]       rd_len,
    input  logic [LEN_W-1:0]       rd_count,
    input  frt_pkg::stream_flags_t rd_flags,
    output logic                   wr_en,
    output logic [LEN_W-1:0]       wr_len,
    output logic [LEN_W-1:0]       wr_count,
    output frt_pkg::stream_flags_t wr_flags
);
    import frt_pkg::*;

    logic [2:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] len_hi_reg, len_hi_next;

    logic              slot_ok;
    logic              we;
    logic              hdr_take;
    logic [HLEN_W-1:0] hdr_len;
    logic [HLEN_W-1:0] cnt_ext;
    logic [HLEN_W-1:0] len_ext;
    logic [LEN_W-1:0]  cnt_inc;
    logic [SLOT_W+CHAN_W-1:0] stream_full;

    assign slot_ok     = ({1'b0, item.slot_index} < 4'(SLOTS));
    assign stream_full = {item.slot_index, item.channel};
    assign idx         = slot_ok ? stream_full[IDX_W-1:0] : '0;
    assign cnt_ext     = HLEN_W'(rd_count);
    assign len_ext     = HLEN_W'(rd_len);
    assign cnt_inc     = rd_count + 1'b1;
    assign wr_en       = fire && we;

    always_comb
    begin
        result             = '0;
        result.out_slot    = item.slot_index;
        result.out_channel = item.channel;
        phase_next         = phase_reg;
        len_hi_next        = len_hi_reg;
        we                 = 1'b0;
        wr_len             = rd_len;
        wr_count           = rd_count;
        wr_flags           = rd_flags;
        hdr_take           = 1'b0;
        hdr_len            = '0;

        if (!slot_ok)
        begin
            result.event_res = EV_IGNORED;
            phase_next       = PH_DROP;
        end
        else
        begin
            if (item.packet_start)
            begin
                if (item.packet_byte[7])
                begin
                    // continuation packet
                    if (!rd_flags.active)
                    begin
                        result.event_res = EV_ORPHAN;
                        phase_next       = PH_DROP;
                    end
                    else if ({1'b0, item.packet_byte[6:0]} != rd_flags.seq)
                    begin
                        we               = 1'b1;
                        wr_flags.active  = 1'b0;
                        result.event_res = EV_SEQ;
                        phase_next       = PH_DROP;
                    end
                    else
                    begin
                        we           = 1'b1;
                        wr_flags.seq = rd_flags.seq + 1'b1;
                        phase_next   = PH_BODY;
                    end
                end
                else
                begin
                    case (item.packet_byte[6:5])
                        HDR_GENERAL:
                        begin
                            hdr_take = 1'b1;
                            hdr_len  = HLEN_W'(item.packet_byte[4:0]);
                        end
                        HDR_EXT13:
                        begin
                            len_hi_next = {3'd0, item.packet_byte[4:0]};
                            phase_next  = PH_EXT13;
                        end
                        HDR_EXT16:
                        begin
                            phase_next = PH_EXT16_HI;
                        end
                        default:
                        begin
                            result.event_res = EV_RESERVED;
                            phase_next       = PH_DROP;
                        end
                    endcase
                end
            end
            else
            begin
                case (phase_reg)
                    PH_EXT13, PH_EXT16_LO:
                    begin
                        hdr_take = 1'b1;
                        hdr_len  = {len_hi_reg, item.packet_byte};
                    end
                    PH_EXT16_HI:
                    begin
                        len_hi_next = item.packet_byte;
                        phase_next  = PH_EXT16_LO;
                    end
                    PH_BODY:
                    begin
                        if (rd_flags.active && (rd_count < rd_len))
                        begin
                            we                    = 1'b1;
                            wr_count              = cnt_inc;
                            result.payload_valid  = 1'b1;
                            result.payload_byte   = item.packet_byte;
                            result.payload_offset = cnt_ext[OFFSET_W-1:0];
                            if (cnt_inc >= rd_len)
                            begin
                                wr_flags.active       = 1'b0;
                                result.event_res      = EV_DONE;
                                result.message_length = len_ext[MLEN_W-1:0];
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // complete start header
            if (hdr_take)
            begin
                if (hdr_len > HLEN_W'(MAX_MESSAGE_LEN))
                begin
                    result.event_res = EV_LARGE;
                    phase_next       = PH_DROP;
                end
                else
                begin
                    we              = 1'b1;
                    wr_len          = hdr_len[LEN_W-1:0];
                    wr_count        = '0;
                    wr_flags.active = (hdr_len != '0);
                    wr_flags.seq    = '0;
                    if (hdr_len == '0)
                    begin
                        result.event_res = EV_DONE;
                    end
                    phase_next = PH_BODY;
                end
            end

            if (item.packet_end && (phase_next == PH_EXT13 || phase_next == PH_EXT16_HI ||
                                    phase_next == PH_EXT16_LO))
            begin
                result.event_res = EV_CUT;
            end
        end

        if (item.packet_end)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            len_hi_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            len_hi_reg <= len_hi_next;
        end
    end

endmodule

// ===== design/frt_checker.sv =====
// ============================================================================
// frt_checker - port-level checks of the fragment reassembly tracker
// Beat ordering and result field consistency seen on the top-level ports.
// ============================================================================
module frt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        pkt_valid,
    input logic                        pkt_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [frt_pkg::EVENT_W-1:0] event_res,
    input logic [frt_pkg::MLEN_W-1:0]  message_length
);
    import frt_pkg::*;

    // a stalled result stays up
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    // every accepted byte has a result waiting once it has passed the input and result registers
    a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_ready |-> ##2 res_valid)
        else $error("no result two cycles after an accepted beat");

    // input backpressure only comes from a stalled result
    a_bp_source: assert property (@(posedge clk) disable iff (!rst_n)
        !pkt_ready |-> res_valid && !res_ready)
        else $error("input stalled without output stall");

    // length is only reported with message complete
    a_len_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (event_res != EV_DONE) |-> message_length == '0)
        else $error("message length outside message complete");

endmodule

bind fragment_reassembly_tracker frt_checker u_frt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pkt_valid      (pkt.valid),
    .pkt_ready      (pkt.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .event_res      (res.event_res),
    .message_length (res.message_length)
);
